FILE: src/itoar_pkg.sv
package itoar_pkg;

  // Conversion mode carried in the low bits of the input item
  typedef enum logic [1:0] {
    MODE_SDEC = 2'd0,
    MODE_UDEC = 2'd1,
    MODE_OCT  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_e;

  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A_LOW = 7'h61;

  // Map one digit value to its lower-case ASCII code
  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + 7'(d);
    end else begin
      c = CHAR_A_LOW + 7'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

FILE: src/integer_to_ascii_radix.sv
// Throughput: one character per cycle while the output accepts (m_axis_tready); a value
// occupies the character emitter until all of its characters (1 to MAX_CHARS) are sent.
// The conversion pipeline takes a new value every cycle while it has room.
// Reset clears all valid bits and the emitter; no data is cleared.
module integer_to_ascii_radix #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_CHARS   = 11,
  localparam int unsigned IN_TDW     = ((2 + VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_TDW-1:0] s_axis_tdata,   // op[1:0], value, zero fill
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // char_code[6:0], zero bit
  output logic              m_axis_tlast
);

  localparam int unsigned ND_DEC = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int unsigned ND_OCT = (VALUE_WIDTH + 2) / 3;
  localparam int unsigned NDIG   = (ND_DEC > ND_OCT) ? ND_DEC : ND_OCT;
  localparam int unsigned IW     = $clog2(NDIG);

  logic                 cv_valid;
  logic                 cv_ready;
  logic [NDIG-1:0][3:0] cv_digits;
  logic [IW-1:0]        cv_top;
  logic                 cv_neg;

  itoar_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_CHARS   (MAX_CHARS),
    .NDIG        (NDIG)
  ) u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_mode_i    (itoar_pkg::mode_e'(s_axis_tdata[1:0])),
    .in_value_i   (s_axis_tdata[2 +: VALUE_WIDTH]),
    .out_valid_o  (cv_valid),
    .out_ready_i  (cv_ready),
    .out_digits_o (cv_digits),
    .out_top_o    (cv_top),
    .out_neg_o    (cv_neg)
  );

  logic                 em_busy_q;
  logic                 em_sign_q;
  logic [IW-1:0]        em_idx_q;
  logic [NDIG-1:0][3:0] em_dig_q;
  logic                 out_v_q;
  logic [6:0]           out_char_q;
  logic                 out_last_q;

  logic                 load;
  logic                 cur_last;
  logic [6:0]           cur_char;

  // Pick the next character and decide when the output register takes it
  always_comb begin
    load     = em_busy_q && (!out_v_q || m_axis_tready);
    cur_last = !em_sign_q && (em_idx_q == '0);
    cur_char = em_sign_q ? itoar_pkg::CHAR_MINUS
                         : itoar_pkg::digit_to_ascii(em_dig_q[em_idx_q]);
    cv_ready = !em_busy_q || (load && cur_last);
  end

  // Emitter: hold one value, step from the sign down to the lowest digit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_busy_q <= 1'b0;
      em_sign_q <= 1'b0;
      em_idx_q  <= '0;
    end else if (cv_valid && cv_ready) begin
      em_busy_q <= 1'b1;
      em_sign_q <= cv_neg;
      em_idx_q  <= cv_top;
    end else if (load) begin
      if (em_sign_q) begin
        em_sign_q <= 1'b0;
      end else if (em_idx_q == '0) begin
        em_busy_q <= 1'b0;
      end else begin
        em_idx_q <= em_idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cv_valid && cv_ready) begin
      em_dig_q <= cv_digits;
    end
  end

  // Output register: load a character, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= cur_char;
      out_last_q <= cur_last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tlast  = out_last_q;

  // A minus sign is always followed by at least one digit
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[6:0] == itoar_pkg::CHAR_MINUS) |-> !m_axis_tlast)
    else $error("minus sign marked as last character");

  // A pending sign only exists inside a value being emitted
  a_sign_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_sign_q |-> em_busy_q)
    else $error("sign pending while emitter idle");

  // A handed-over value always leaves the emitter busy
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_valid && cv_ready |=> em_busy_q)
    else $error("emitter not busy after taking a value");

  // Digit index stays inside the digit register
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_busy_q |-> (32'(em_idx_q) < NDIG))
    else $error("digit index out of range");

endmodule

FILE: src/itoar_conv.sv
module itoar_conv #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_CHARS   = 11,
  parameter int unsigned NDIG        = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  itoar_pkg::mode_e          in_mode_i,
  input  logic [VALUE_WIDTH-1:0]    in_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [NDIG-1:0][3:0]      out_digits_o,
  output logic [$clog2(NDIG)-1:0]   out_top_o,
  output logic                      out_neg_o
);

  localparam int unsigned ND  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int unsigned TW  = 4 * ND + VALUE_WIDTH;
  localparam int unsigned BPS = 4;
  localparam int unsigned NST = (VALUE_WIDTH + BPS - 1) / BPS;
  localparam int unsigned NS  = NST + 3;
  localparam int unsigned LS  = NST + 1;
  localparam int unsigned PW  = 4 * NDIG;
  localparam int unsigned IW  = $clog2(NDIG);

  // One shift-and-correct pass over BPS input bits; corrections only in decimal
  function automatic logic [TW-1:0] dabble(input logic [TW-1:0] x, input logic dec,
                                           input int unsigned base);
    logic [TW-1:0] r;
    logic [3:0]    nib;
    r = x;
    for (int b = 0; b < BPS; b++) begin
      if (base + b < VALUE_WIDTH) begin
        for (int k = 0; k < ND; k++) begin
          nib = r[VALUE_WIDTH + 4 * k +: 4];
          if (dec && nib >= 4'd5) begin
            r[VALUE_WIDTH + 4 * k +: 4] = nib + 4'd3;
          end
        end
        r = {r[TW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [NS-1:0]          v_q;
  logic [NS:0]            rdy;
  itoar_pkg::mode_e       mode0_q;
  logic [VALUE_WIDTH-1:0] val0_q;
  itoar_pkg::mode_e       mode_q [1:LS];
  logic                   neg_q  [1:LS];
  logic [TW-1:0]          sr_q   [1:LS];
  logic [NDIG-1:0][3:0]   dig_q;
  logic [IW-1:0]          top_q;
  logic                   negf_q;

  // Stall chain: a stage takes new data when empty or when it moves on
  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k + 1];
    end
  end

  assign in_ready_o = rdy[0];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k - 1];
        end
      end
    end
  end

  // Input stage
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mode0_q <= in_mode_i;
      val0_q  <= in_value_i;
    end
  end

  // Sign and magnitude stage
  logic                   neg1;
  logic [VALUE_WIDTH-1:0] mag1;

  always_comb begin
    neg1 = (mode0_q == itoar_pkg::MODE_SDEC) && val0_q[VALUE_WIDTH-1];
    mag1 = neg1 ? (~val0_q + 1'b1) : val0_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      mode_q[1] <= mode0_q;
      neg_q[1]  <= neg1;
      sr_q[1]   <= TW'(mag1);
    end
  end

  // Double-dabble stages; non-decimal modes shift the binary through unchanged
  for (genvar j = 2; j <= LS; j++) begin : g_dabble
    always_ff @(posedge clk_i) begin
      if (rdy[j]) begin
        mode_q[j] <= mode_q[j - 1];
        neg_q[j]  <= neg_q[j - 1];
        sr_q[j]   <= dabble(sr_q[j - 1],
                            (mode_q[j - 1] == itoar_pkg::MODE_SDEC) ||
                            (mode_q[j - 1] == itoar_pkg::MODE_UDEC),
                            (j - 2) * BPS);
      end
    end
  end

  // Digit stage: split into digits, find the leading one, apply the length cap
  logic [PW-1:0]        pad;
  logic [NDIG-1:0][3:0] dig_d;
  int unsigned          hi;
  int unsigned          cap_m1;
  int unsigned          top;

  always_comb begin
    pad = PW'(sr_q[LS][TW-1:VALUE_WIDTH]);
    for (int i = 0; i < NDIG; i++) begin
      if (mode_q[LS] == itoar_pkg::MODE_OCT) begin
        dig_d[i] = {1'b0, pad[3 * i +: 3]};
      end else begin
        dig_d[i] = pad[4 * i +: 4];
      end
    end
    hi = 0;
    for (int i = 0; i < NDIG; i++) begin
      if (dig_d[i] != 4'd0) begin
        hi = i;
      end
    end
    cap_m1 = neg_q[LS] ? MAX_CHARS - 2 : MAX_CHARS - 1;
    top    = (hi < cap_m1) ? hi : cap_m1;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS - 1]) begin
      dig_q  <= dig_d;
      top_q  <= IW'(top);
      negf_q <= neg_q[LS];
    end
  end

  assign out_valid_o  = v_q[NS-1];
  assign out_digits_o = dig_q;
  assign out_top_o    = top_q;
  assign out_neg_o    = negf_q;

endmodule

FILE: tb/char_checker.sv
`timescale 1ns / 1ps

// Watch both streams, predict the text of every value taken in and compare
// each character that leaves against the oldest one still owed.
module char_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // op[1:0], value[33:2], zero fill
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // char_code[6:0], zero bit
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          owed_chars_o,
  output int          chars_seen_o
);

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  text_char_t owed_chars[$];

  // Render one word in the given mode and queue its characters
  function automatic void queue_text(input itoar_pkg::mode_e mode,
                                     input logic [31:0] word);
    logic [31:0] mag;
    logic        neg;
    int unsigned radix;
    int unsigned cap;
    int unsigned ndig;
    logic [3:0]  digits [11];
    logic [3:0]  d;
    text_char_t  tc;
    int          i;
    mag  = word;
    neg  = 1'b0;
    ndig = 0;
    // take the magnitude as unsigned so the most negative word works too
    if (mode == itoar_pkg::MODE_SDEC && word[31]) begin
      neg = 1'b1;
      mag = 32'd0 - word;
    end
    radix = (mode == itoar_pkg::MODE_OCT) ? 8 : (mode == itoar_pkg::MODE_HEX) ? 16 : 10;
    cap   = neg ? 10 : 11;
    do begin
      if (ndig < cap) begin
        digits[ndig] = 4'(mag % radix);
        ndig++;
      end
      mag = mag / radix;
    end while (mag != 32'd0);
    if (neg) begin
      tc.code = {1'b0, itoar_pkg::CHAR_MINUS};
      tc.last = 1'b0;
      owed_chars.push_back(tc);
    end
    for (i = int'(ndig) - 1; i >= 0; i--) begin
      d = digits[i];
      tc.code = {1'b0, (d < 4'd10) ? itoar_pkg::CHAR_ZERO + 7'(d)
                                   : itoar_pkg::CHAR_A_LOW + 7'(d - 4'd10)};
      tc.last = (i == 0);
      owed_chars.push_back(tc);
    end
  endfunction

  // Predict on every item taken in, compare on every item sent out
  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      owed_chars.delete();
      fail_count_o <= 0;
      chars_seen_o <= 0;
      owed_chars_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        chars_seen_o <= chars_seen_o + 1;
        if (owed_chars.size() == 0) begin
          $display("%0t: unexpected character tdata=%h tlast=%b",
                   $time, m_axis_tdata, m_axis_tlast);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = owed_chars.pop_front();
          if (m_axis_tdata !== want.code || m_axis_tlast !== want.last) begin
            $display("%0t: character mismatch: expected tdata=%h tlast=%b, %s%h tlast=%b",
                     $time, want.code, want.last, "got tdata=", m_axis_tdata,
                     m_axis_tlast);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        queue_text(itoar_pkg::mode_e'(s_axis_tdata[1:0]), s_axis_tdata[33:2]);
      end
      owed_chars_o <= owed_chars.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_VALUES = 126;
  localparam int QUIET_VALUES = 25;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // op[1:0], value[33:2], zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;   // char_code[6:0], zero bit
  logic        m_axis_tlast;

  int   fail_count;
  int   owed_chars;
  int   chars_seen;
  int   values_sent;
  int   idle_cycles = 0;
  int   ready_left = 0;
  logic no_idle;

  integer_to_ascii_radix i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  char_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .owed_chars_o  (owed_chars),
    .chars_seen_o  (chars_seen)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stall the output side in random bursts between open stretches; always open once no_idle is set
  always @(posedge clk_i) begin
    if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (ready_left == 0) begin
      ready_left    <= $urandom_range(1, 19);
      m_axis_tready <= ($urandom_range(0, 2) != 0);
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one value, sometimes with a random gap ahead of it, and hold until it is taken
  task automatic send_value(input itoar_pkg::mode_e mode, input logic [31:0] word);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, word, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    values_sent++;
  endtask

  // Pick a word that lands near digit, sign and width boundaries often
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0: w = $urandom();
      1: w = $urandom_range(0, 999);
      2: w = (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
      3: w = 32'h8000_0000 + 32'($urandom_range(0, 15));
      4: w = 32'h7fff_ffff - 32'($urandom_range(0, 15));
      default: w = 32'd0 - 32'($urandom_range(1, 1000));
    endcase
    return w;
  endfunction

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    no_idle       <= 1'b0;
    values_sent   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // signed decimal: zero, unit, sign boundary, most negative, digit roll-over
    send_value(itoar_pkg::MODE_SDEC, 32'd0);
    send_value(itoar_pkg::MODE_SDEC, 32'd1);
    send_value(itoar_pkg::MODE_SDEC, 32'hffff_ffff);
    send_value(itoar_pkg::MODE_SDEC, 32'h7fff_ffff);
    send_value(itoar_pkg::MODE_SDEC, 32'h8000_0000);
    send_value(itoar_pkg::MODE_SDEC, 32'h8000_0001);
    send_value(itoar_pkg::MODE_SDEC, 32'd9);
    send_value(itoar_pkg::MODE_SDEC, 32'd10);
    send_value(itoar_pkg::MODE_SDEC, 32'hffff_fff6);
    // unsigned decimal: zero, widest text, ten-digit boundary
    send_value(itoar_pkg::MODE_UDEC, 32'd0);
    send_value(itoar_pkg::MODE_UDEC, 32'hffff_ffff);
    send_value(itoar_pkg::MODE_UDEC, 32'd999_999_999);
    send_value(itoar_pkg::MODE_UDEC, 32'd1_000_000_000);
    send_value(itoar_pkg::MODE_UDEC, 32'h8000_0000);
    // octal: zero, one-digit edge, eleven-digit maximum
    send_value(itoar_pkg::MODE_OCT, 32'd0);
    send_value(itoar_pkg::MODE_OCT, 32'd7);
    send_value(itoar_pkg::MODE_OCT, 32'd8);
    send_value(itoar_pkg::MODE_OCT, 32'hffff_ffff);
    // hex: zero, letter digits, full width
    send_value(itoar_pkg::MODE_HEX, 32'd0);
    send_value(itoar_pkg::MODE_HEX, 32'd15);
    send_value(itoar_pkg::MODE_HEX, 32'h10);
    send_value(itoar_pkg::MODE_HEX, 32'hdead_beef);
    send_value(itoar_pkg::MODE_HEX, 32'hffff_ffff);
    send_value(itoar_pkg::MODE_HEX, 32'd10);

    // random words in random modes; the tail runs with no idling
    for (int k = 0; k < RANDOM_VALUES; k++) begin
      if (k == RANDOM_VALUES - QUIET_VALUES) no_idle <= 1'b1;
      send_value(itoar_pkg::mode_e'($urandom_range(0, 3)), pick_word());
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    // drain, then give the block time to show any stray characters
    while (owed_chars != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d values in all four modes, %0d characters compared",
             values_sent, chars_seen);
    $display("summary: %0d mismatches or stray characters", fail_count);
    if (fail_count == 0 && owed_chars == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: integer_to_ascii_radix.f
src/itoar_pkg.sv
src/itoar_conv.sv
src/integer_to_ascii_radix.sv
tb/char_checker.sv
tb/tb.sv
